FILE: hdl/lpf_pkg.sv
// Package for the lookahead point finder: widths, register indexes, reset values,
// unit opcodes, sequencer states and the control struct of the shared unit.
// No dependencies.
package lpf_pkg;

	localparam int DEF_COORD_WIDTH = 32;
	localparam int DEF_FRAC_BITS   = 16;
	localparam int SPEED_WIDTH     = 32;
	localparam int LA_WIDTH        = 32;
	localparam int LT_WIDTH        = 20;
	localparam int LEN_WIDTH       = 23;
	localparam int CFG_DATA_WIDTH  = 23;
	localparam int CFG_IDX_WIDTH   = 2;

	localparam logic [LT_WIDTH-1:0]  RST_LA_TIME = LT_WIDTH'(98304);
	localparam logic [LEN_WIDTH-1:0] RST_MIN_LA  = LEN_WIDTH'(19661);
	localparam logic [LEN_WIDTH-1:0] RST_MAX_LA  = LEN_WIDTH'(58982);

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_LA_TIME    = 2'd0,
		REG_MIN_LA     = 2'd1,
		REG_MAX_LA     = 2'd2,
		REG_USE_INTERP = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_SQRT
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_ctl_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LA_MUL,
		ST_X2SQ,
		ST_Y2SQ,
		ST_R2,
		ST_TEST,
		ST_DR2X,
		ST_DR2Y,
		ST_X1SQ,
		ST_Y1SQ,
		ST_DCA,
		ST_DCB,
		ST_DISCA,
		ST_DISCB,
		ST_SQRT,
		ST_TX,
		ST_NUMX,
		ST_DIVX,
		ST_TY,
		ST_NUMY,
		ST_DIVY,
		ST_OUT
	} state_t;

endpackage

FILE: hdl/lpf_if.sv
// Channel interfaces of the lookahead point finder: path points in, carrots out.
// Depends on lpf_pkg.
interface lpf_path_if import lpf_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [SPEED_WIDTH-1:0] speed_x;
	logic                          first_point;
	logic                          last_point;

	modport source (output valid, point_x, point_y, speed_x, first_point, last_point,
		input ready);
	modport sink (input valid, point_x, point_y, speed_x, first_point, last_point,
		output ready);
endinterface

interface lpf_carrot_if import lpf_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] carrot_x;
	logic signed [COORD_WIDTH-1:0] carrot_y;
	logic                          interpolated;
	logic                          from_path_end;

	modport source (output valid, carrot_x, carrot_y, interpolated, from_path_end,
		input ready);
	modport sink (input valid, carrot_x, carrot_y, interpolated, from_path_end,
		output ready);
endinterface

FILE: hdl/lpf_alu.sv
// Shared iterative arithmetic unit: unsigned shift-add multiply, restoring divide
// and restoring square root, one step per cycle. Depends on lpf_pkg.
module lpf_alu import lpf_pkg::*; #(
	parameter int W = 134
) (
	input  logic         clk,
	input  logic         arst_n,
	input  alu_ctl_t     ctl,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] res,
	output logic         done
);
	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	alu_op_t       op_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  x_q;
	logic [W-1:0]  y_q;
	logic [W-1:0]  d_q;
	logic [CW-1:0] cnt_q;
	logic          finish;
	logic [W-1:0]  sub_a;
	logic [W-1:0]  sub_b;
	logic [W:0]    diff;
	logic          ge;

	always_comb begin
		case (op_q)
			ALU_MUL:  finish = (y_q == '0);
			ALU_DIV:  finish = (cnt_q == '0);
			ALU_SQRT: finish = (d_q == '0);
			default:  finish = 1'b1;
		endcase
	end

	assign done = busy_q && finish;
	assign res  = (op_q == ALU_MUL) ? acc_q : y_q;

	// One subtractor serves both the divide and the root step.
	always_comb begin
		if (op_q == ALU_DIV) begin
			sub_a = {acc_q[W-2:0], x_q[W-1]};
			sub_b = d_q;
		end else begin
			sub_a = x_q;
			sub_b = y_q + d_q;
		end
	end

	assign diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign ge   = !diff[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			op_q   <= ALU_MUL;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			op_q   <= ctl.op;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			case (ctl.op)
				ALU_DIV: begin
					acc_q <= '0;
					x_q   <= a;
					y_q   <= '0;
					d_q   <= b;
					cnt_q <= CW'(W);
				end
				ALU_SQRT: begin
					x_q <= a;
					y_q <= '0;
					d_q <= W'(1) << (W - 2);
				end
				default: begin
					acc_q <= '0;
					x_q   <= a;
					y_q   <= b;
				end
			endcase
		end else if (busy_q && !finish) begin
			case (op_q)
				ALU_MUL: begin
					if (y_q[0]) begin
						acc_q <= acc_q + x_q;
					end
					x_q <= x_q << 1;
					y_q <= y_q >> 1;
				end
				ALU_DIV: begin
					acc_q <= ge ? diff[W-1:0] : sub_a;
					x_q   <= x_q << 1;
					y_q   <= {y_q[W-2:0], ge};
					cnt_q <= cnt_q - CW'(1);
				end
				ALU_SQRT: begin
					if (ge) begin
						x_q <= diff[W-1:0];
						y_q <= (y_q >> 1) + d_q;
					end else begin
						y_q <= y_q >> 1;
					end
					d_q <= d_q >> 2;
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

endmodule

FILE: hdl/lookahead_point_finder.sv
// Sequence: a point that gives no carrot squares |x|, |y| and the lookahead by shift-add
// multiplies; a first point also multiplies its speed by the lookahead time to set it.
// A carrot adds an output state; interpolation adds two divides, a root and twelve
// multiplies in the shared unit, W = 4*COORD_WIDTH+6 bits wide by default.
// Flow: one point at a time, ready only while the sequencer idles; one result may wait.
// Reset: asynchronous, active low; sequencer and config state take defaults, no clearing pass.
module lookahead_point_finder import lpf_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH,
	parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wen,
	input  logic [CFG_IDX_WIDTH-1:0]  cfg_idx,
	input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
	lpf_path_if.sink                  path,
	lpf_carrot_if.source              carrot
);
	localparam int C    = COORD_WIDTH;
	localparam int MAXW = (4 * C > 2 * C + 2 * LA_WIDTH + 1) ? 4 * C
		: 2 * C + 2 * LA_WIDTH + 1;
	localparam int W    = 2 * ((MAXW + 6) / 2);

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		return v[W-1] ? -v : v;
	endfunction

	function automatic logic [C-1:0] sat(input logic [W-1:0] q, input logic neg);
		logic [W-1:0] lim;
		logic [W-1:0] m;
		lim = neg ? (W'(1) << (C - 1)) : ((W'(1) << (C - 1)) - W'(1));
		m   = (q > lim) ? lim : q;
		return neg ? -m[C-1:0] : m[C-1:0];
	endfunction

	state_t               state_q, state_d;
	logic                 issued_q;
	logic [LT_WIDTH-1:0]  lt_q;
	logic [LEN_WIDTH-1:0] min_q;
	logic [LEN_WIDTH-1:0] max_q;
	logic                 interp_en_q;
	logic [LA_WIDTH-1:0]  la_q;
	logic [C-1:0]         prev_x_q;
	logic [C-1:0]         prev_y_q;
	logic                 carrot_done_q;
	logic                 out_valid_q;

	logic [C-1:0]           x2_q, y2_q;
	logic [SPEED_WIDTH-1:0] speed_q;
	logic                   first_q, last_q;
	logic [W-1:0]           acc_q, d2_q, r2_q, dr2_q, dc_q, s_q;
	logic                   dd_neg_q;
	logic [C-1:0]           cx_q, cy_q;
	logic                   interp_q, pend_q;
	logic [C-1:0]           out_x_q, out_y_q;
	logic                   out_interp_q, out_pend_q;

	logic [W-1:0] x2w, y2w, x1w, y1w, dxw, dyw;
	logic [SPEED_WIDTH-1:0] spd_abs;
	logic [W-1:0] spd_mag, la_full, la_clamped;
	logic [W-1:0] alu_a, alu_b, alu_res, mres, acc_next, div_num;
	alu_op_t      alu_op;
	alu_ctl_t     alu_ctl;
	logic         alu_done, is_alu, mneg, mclr, reach, accept;

	assign x2w = {{(W - C){x2_q[C-1]}}, x2_q};
	assign y2w = {{(W - C){y2_q[C-1]}}, y2_q};
	assign x1w = {{(W - C){prev_x_q[C-1]}}, prev_x_q};
	assign y1w = {{(W - C){prev_y_q[C-1]}}, prev_y_q};
	assign dxw = x2w - x1w;
	assign dyw = y2w - y1w;

	// The magnitude is taken at the speed width, so the most negative speed gives 2^31.
	assign spd_abs = speed_q[SPEED_WIDTH-1] ? -speed_q : speed_q;
	assign spd_mag = W'(spd_abs);
	assign reach   = (d2_q >= r2_q);
	assign div_num = (mag(acc_q) << 1) + dr2_q;
	assign accept  = path.valid && path.ready;

	always_comb begin
		state_d = state_q;
		alu_op  = ALU_MUL;
		alu_a   = '0;
		alu_b   = '0;
		mneg    = 1'b0;
		mclr    = 1'b0;
		is_alu  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				is_alu = 1'b0;
				if (path.valid) begin
					if (path.first_point) begin
						state_d = ST_LA_MUL;
					end else if (!carrot_done_q) begin
						state_d = ST_X2SQ;
					end
				end
			end
			ST_LA_MUL: begin
				alu_a = spd_mag;
				alu_b = W'(lt_q);
				mclr  = 1'b1;
				if (alu_done) state_d = ST_X2SQ;
			end
			ST_X2SQ: begin
				alu_a = mag(x2w);
				alu_b = mag(x2w);
				mclr  = 1'b1;
				if (alu_done) state_d = ST_Y2SQ;
			end
			ST_Y2SQ: begin
				alu_a = mag(y2w);
				alu_b = mag(y2w);
				if (alu_done) state_d = ST_R2;
			end
			ST_R2: begin
				alu_a = W'(la_q);
				alu_b = W'(la_q);
				mclr  = 1'b1;
				if (alu_done) state_d = ST_TEST;
			end
			ST_TEST: begin
				is_alu = 1'b0;
				if (reach) begin
					state_d = (interp_en_q && !first_q) ? ST_DR2X : ST_OUT;
				end else begin
					state_d = last_q ? ST_OUT : ST_IDLE;
				end
			end
			ST_DR2X: begin
				alu_a = mag(dxw);
				alu_b = mag(dxw);
				mclr  = 1'b1;
				if (alu_done) state_d = ST_DR2Y;
			end
			ST_DR2Y: begin
				alu_a = mag(dyw);
				alu_b = mag(dyw);
				if (alu_done) state_d = (acc_next == '0) ? ST_OUT : ST_X1SQ;
			end
			ST_X1SQ: begin
				alu_a = mag(x1w);
				alu_b = mag(x1w);
				mclr  = 1'b1;
				if (alu_done) state_d = ST_Y1SQ;
			end
			ST_Y1SQ: begin
				alu_a = mag(y1w);
				alu_b = mag(y1w);
				if (alu_done) state_d = ST_DCA;
			end
			ST_DCA: begin
				alu_a = mag(x1w);
				alu_b = mag(y2w);
				mneg  = x1w[W-1] ^ y2w[W-1];
				mclr  = 1'b1;
				if (alu_done) state_d = ST_DCB;
			end
			ST_DCB: begin
				alu_a = mag(x2w);
				alu_b = mag(y1w);
				mneg  = !(x2w[W-1] ^ y1w[W-1]);
				if (alu_done) state_d = ST_DISCA;
			end
			ST_DISCA: begin
				alu_a = r2_q;
				alu_b = dr2_q;
				mclr  = 1'b1;
				if (alu_done) state_d = ST_DISCB;
			end
			ST_DISCB: begin
				alu_a = mag(dc_q);
				alu_b = mag(dc_q);
				mneg  = 1'b1;
				if (alu_done) state_d = ST_SQRT;
			end
			ST_SQRT: begin
				alu_op = ALU_SQRT;
				alu_a  = acc_q;
				if (alu_done) state_d = ST_TX;
			end
			ST_TX: begin
				alu_a = mag(dxw);
				alu_b = s_q;
				mneg  = dxw[W-1] ^ dd_neg_q;
				mclr  = 1'b1;
				if (alu_done) state_d = ST_NUMX;
			end
			ST_NUMX: begin
				alu_a = mag(dc_q);
				alu_b = mag(dyw);
				mneg  = dc_q[W-1] ^ dyw[W-1];
				if (alu_done) state_d = ST_DIVX;
			end
			ST_DIVX: begin
				alu_op = ALU_DIV;
				alu_a  = div_num;
				alu_b  = dr2_q << 1;
				if (alu_done) state_d = ST_TY;
			end
			ST_TY: begin
				alu_a = mag(dyw);
				alu_b = s_q;
				mneg  = dyw[W-1] ^ dd_neg_q;
				mclr  = 1'b1;
				if (alu_done) state_d = ST_NUMY;
			end
			ST_NUMY: begin
				alu_a = mag(dc_q);
				alu_b = mag(dxw);
				mneg  = !(dc_q[W-1] ^ dxw[W-1]);
				if (alu_done) state_d = ST_DIVY;
			end
			ST_DIVY: begin
				alu_op = ALU_DIV;
				alu_a  = div_num;
				alu_b  = dr2_q << 1;
				if (alu_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				is_alu = 1'b0;
				if (!out_valid_q || carrot.ready) state_d = ST_IDLE;
			end
			default: begin
				is_alu  = 1'b0;
				state_d = ST_IDLE;
			end
		endcase
	end

	assign alu_ctl.start = is_alu && !issued_q;
	assign alu_ctl.op    = alu_op;

	always_comb begin
		mres     = mneg ? -alu_res : alu_res;
		acc_next = (mclr ? '0 : acc_q) + mres;
	end

	// The lookahead product drops its fraction, then the lower clamp takes priority.
	always_comb begin
		la_full = alu_res >> FRAC_BITS;
		if (la_full < W'(min_q)) begin
			la_clamped = W'(min_q);
		end else if (la_full > W'(max_q)) begin
			la_clamped = W'(max_q);
		end else begin
			la_clamped = la_full;
		end
	end

	lpf_alu #(
		.W (W)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.a      (alu_a),
		.b      (alu_b),
		.res    (alu_res),
		.done   (alu_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			issued_q      <= 1'b0;
			lt_q          <= RST_LA_TIME;
			min_q         <= RST_MIN_LA;
			max_q         <= RST_MAX_LA;
			interp_en_q   <= 1'b1;
			la_q          <= '0;
			prev_x_q      <= '0;
			prev_y_q      <= '0;
			carrot_done_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (alu_done) begin
				issued_q <= 1'b0;
			end else if (alu_ctl.start) begin
				issued_q <= 1'b1;
			end
			if (cfg_wen) begin
				case (cfg_reg_t'(cfg_idx))
					REG_LA_TIME:    lt_q        <= cfg_wdata[LT_WIDTH-1:0];
					REG_MIN_LA:     min_q       <= cfg_wdata[LEN_WIDTH-1:0];
					REG_MAX_LA:     max_q       <= cfg_wdata[LEN_WIDTH-1:0];
					REG_USE_INTERP: interp_en_q <= cfg_wdata[0];
					default:        interp_en_q <= interp_en_q;
				endcase
			end
			if (accept && path.first_point) begin
				carrot_done_q <= 1'b0;
			end
			if (state_q == ST_LA_MUL && alu_done) begin
				la_q <= la_clamped[LA_WIDTH-1:0];
			end
			if (state_q == ST_TEST) begin
				if (reach || last_q) begin
					carrot_done_q <= 1'b1;
				end
				if (!reach) begin
					prev_x_q <= x2_q;
					prev_y_q <= y2_q;
				end
			end
			if (state_q == ST_OUT && state_d == ST_IDLE) begin
				out_valid_q <= 1'b1;
			end else if (carrot.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x2_q    <= path.point_x;
			y2_q    <= path.point_y;
			speed_q <= path.speed_x;
			first_q <= path.first_point;
			last_q  <= path.last_point;
		end
		if (alu_done && alu_op == ALU_MUL) begin
			acc_q <= (state_q == ST_DISCB && acc_next[W-1]) ? '0 : acc_next;
		end
		if (alu_done) begin
			case (state_q)
				ST_Y2SQ: d2_q     <= acc_next;
				ST_R2:   r2_q     <= alu_res;
				ST_DR2Y: dr2_q    <= acc_next;
				ST_Y1SQ: dd_neg_q <= $signed(d2_q) < $signed(acc_next);
				ST_DCB:  dc_q     <= acc_next;
				ST_SQRT: s_q      <= alu_res;
				ST_DIVX: cx_q     <= sat(alu_res, acc_q[W-1]);
				ST_DIVY: begin
					cy_q     <= sat(alu_res, acc_q[W-1]);
					interp_q <= 1'b1;
				end
				default: dc_q <= dc_q;
			endcase
		end
		if (state_q == ST_TEST) begin
			cx_q     <= x2_q;
			cy_q     <= y2_q;
			interp_q <= 1'b0;
			pend_q   <= !reach;
		end
		if (state_q == ST_OUT && state_d == ST_IDLE) begin
			out_x_q      <= cx_q;
			out_y_q      <= cy_q;
			out_interp_q <= interp_q;
			out_pend_q   <= pend_q;
		end
	end

	assign path.ready           = (state_q == ST_IDLE);
	assign carrot.valid         = out_valid_q;
	assign carrot.carrot_x      = out_x_q;
	assign carrot.carrot_y      = out_y_q;
	assign carrot.interpolated  = out_interp_q;
	assign carrot.from_path_end = out_pend_q;

endmodule

FILE: hdl/lpf_checker.sv
// Port-level checks for the lookahead point finder, bound to the top level.
// Depends on lpf_pkg and lookahead_point_finder.
module lpf_checker import lpf_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   path_ready,
	input logic                   carrot_valid,
	input logic                   carrot_ready,
	input logic [COORD_WIDTH-1:0] carrot_x,
	input logic [COORD_WIDTH-1:0] carrot_y,
	input logic                   interpolated,
	input logic                   from_path_end
);

	// A new carrot only appears after the sequencer has been busy.
	a_carrot_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(carrot_valid) |-> $past(!path_ready))
		else $error("carrot beat appeared while the block was idle");

	a_carrot_held: assert property (@(posedge clk) disable iff (!arst_n)
		carrot_valid && !carrot_ready |=> carrot_valid && $stable(carrot_x)
			&& $stable(carrot_y))
		else $error("stalled carrot beat changed");

	// An interpolated carrot always comes from a point that reached the circle.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		carrot_valid |-> !(interpolated && from_path_end))
		else $error("carrot beat marked both interpolated and path end");

	a_empty_after_reset: assert property (@(posedge clk)
		!arst_n |=> !carrot_valid)
		else $error("carrot beat present straight after reset");

endmodule

bind lookahead_point_finder lpf_checker #(
	.COORD_WIDTH (COORD_WIDTH)
) u_lpf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.path_ready    (path.ready),
	.carrot_valid  (carrot.valid),
	.carrot_ready  (carrot.ready),
	.carrot_x      (carrot.carrot_x),
	.carrot_y      (carrot.carrot_y),
	.interpolated  (carrot.interpolated),
	.from_path_end (carrot.from_path_end)
);

FILE: tb/sv/lookahead_point_finder_tb.sv
// Testbench of the lookahead point finder: drives paths of points through the block,
// predicts each carrot in wide integer arithmetic and checks every result beat.
// Depends on lpf_pkg, the channel interfaces and the lookahead_point_finder RTL.
`timescale 1ns / 100ps

module lookahead_point_finder_tb;
	import lpf_pkg::*;

	localparam int  CW        = DEF_COORD_WIDTH;
	localparam int  FB        = DEF_FRAC_BITS;
	localparam int  SETTLE    = 700;
	localparam int  LIMIT     = 6000000;
	localparam int  MAX_LEN   = 6553600;
	localparam int  MAX_LT    = 655360;

	typedef struct {
		logic signed [CW-1:0]          x;
		logic signed [CW-1:0]          y;
		logic signed [SPEED_WIDTH-1:0] speed;
		logic                          first;
		logic                          last;
	} point_t;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic                 interp;
		logic                 path_end;
	} carrot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_WIDTH-1:0] cfg_idx = '0;
	logic [CFG_DATA_WIDTH-1:0] cfg_wdata = '0;

	lpf_path_if   #(.COORD_WIDTH(CW)) path_ch ();
	lpf_carrot_if #(.COORD_WIDTH(CW)) carrot_ch ();

	lookahead_point_finder #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .path(path_ch), .carrot(carrot_ch)
	);

	// Predictor state and its copy of the registers.
	logic [LT_WIDTH-1:0]  la_time;
	logic [LEN_WIDTH-1:0] min_la;
	logic [LEN_WIDTH-1:0] max_la;
	logic                 use_interp;
	logic [LA_WIDTH-1:0]  look_dist;
	logic signed [CW-1:0] prev_x;
	logic signed [CW-1:0] prev_y;
	logic                 carrot_given;

	carrot_t pending_carrots[$];
	int errors = 0;
	int cycles = 0;
	int send_idle = 0;
	int recv_stall = 0;
	int hold_left = 0;

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [255:0] isqrt(input logic [255:0] n);
		logic [255:0] res, t;
		res = '0;
		for (int i = 127; i >= 0; i--) begin
			t = res | (256'd1 << i);
			if (t * t <= n)
				res = t;
		end
		return res;
	endfunction

	// Round half away from zero, then saturate to the coordinate width.
	function automatic logic [CW-1:0] round_div(input logic signed [255:0] num,
			input logic signed [255:0] den);
		logic [255:0] a, d, q, cap;
		logic neg;
		neg = num < 0;
		a = neg ? -num : num;
		d = den;
		q = (2 * a + d) / (2 * d);
		cap = neg ? (256'd1 << (CW - 1)) : ((256'd1 << (CW - 1)) - 1);
		if (q > cap)
			q = cap;
		return neg ? -q[CW-1:0] : q[CW-1:0];
	endfunction

	function automatic bit find_carrot(input point_t p, output carrot_t c);
		logic [31:0] mag;
		logic [63:0] la;
		logic signed [255:0] x1, y1, x2, y2, r, d2, dx, dy, dr2, dd, dc, disc, s, tx, ty;
		c = '{p.x, p.y, 1'b0, 1'b0};
		if (p.first) begin
			mag = p.speed[31] ? (~p.speed + 32'd1) : p.speed;
			la = ({32'd0, mag} * {44'd0, la_time}) >> FB;
			if (la < min_la)
				la = min_la;
			else if (la > max_la)
				la = max_la;
			look_dist = la[LA_WIDTH-1:0];
			carrot_given = 1'b0;
		end
		if (carrot_given)
			return 0;
		x2 = p.x;
		y2 = p.y;
		r = $signed({224'd0, look_dist});
		d2 = x2 * x2 + y2 * y2;
		if (d2 >= r * r) begin
			if (use_interp && !p.first) begin
				x1 = prev_x;
				y1 = prev_y;
				dx = x2 - x1;
				dy = y2 - y1;
				dr2 = dx * dx + dy * dy;
				// A segment of zero length keeps the point itself.
				if (dr2 != 0) begin
					dd = d2 - (x1 * x1 + y1 * y1);
					dc = x1 * y2 - x2 * y1;
					disc = r * r * dr2 - dc * dc;
					if (disc < 0)
						disc = 0;
					s = $signed(isqrt(disc));
					tx = dx * s;
					ty = dy * s;
					if (dd < 0) begin
						tx = -tx;
						ty = -ty;
					end
					c.x = round_div(dc * dy + tx, dr2);
					c.y = round_div(-(dc * dx) + ty, dr2);
					c.interp = 1'b1;
				end
			end
			carrot_given = 1'b1;
			return 1;
		end
		prev_x = p.x;
		prev_y = p.y;
		if (p.last) begin
			c.path_end = 1'b1;
			carrot_given = 1'b1;
			return 1;
		end
		return 0;
	endfunction

	task automatic send_point(input point_t p);
		carrot_t c;
		while ($urandom_range(99) < send_idle) begin
			path_ch.valid = 1'b0;
			@(negedge clk);
		end
		path_ch.point_x = p.x;
		path_ch.point_y = p.y;
		path_ch.speed_x = p.speed;
		path_ch.first_point = p.first;
		path_ch.last_point = p.last;
		path_ch.valid = 1'b1;
		do @(posedge clk); while (!path_ch.ready);
		if (find_carrot(p, c))
			pending_carrots.push_back(c);
		@(negedge clk);
		path_ch.valid = 1'b0;
	endtask

	// Waits for the block to drain, including points still being worked on.
	task automatic wait_idle();
		while (pending_carrots.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_WIDTH-1:0] val);
		cfg_idx = idx;
		cfg_wdata = val;
		cfg_wen = 1'b1;
		@(negedge clk);
		cfg_wen = 1'b0;
		case (idx)
			REG_LA_TIME:    la_time = val[LT_WIDTH-1:0];
			REG_MIN_LA:     min_la = val;
			REG_MAX_LA:     max_la = val;
			REG_USE_INTERP: use_interp = val[0];
			default:        use_interp = use_interp;
		endcase
	endtask

	task automatic set_config(input int lt, input int mn, input int mx, input bit ip);
		wait_idle();
		write_reg(REG_LA_TIME, CFG_DATA_WIDTH'(lt));
		write_reg(REG_MIN_LA, CFG_DATA_WIDTH'(mn));
		write_reg(REG_MAX_LA, CFG_DATA_WIDTH'(mx));
		write_reg(REG_USE_INTERP, CFG_DATA_WIDTH'(ip));
	endtask

	function automatic point_t mk(input int x, input int y, input int sp,
			input bit f, input bit l);
		point_t p;
		p = '{x, y, sp, f, l};
		return p;
	endfunction

	function automatic int rnd_signed(input int mag);
		int v;
		v = $urandom_range(mag);
		return $urandom_range(1) ? -v : v;
	endfunction

	// A path walks outwards from near the robot, so it usually crosses the circle.
	task automatic send_path();
		int n, sx, sy, scale, ox, oy, sp;
		bit wild;
		n = $urandom_range(1, 8);
		scale = 1 << $urandom_range(10, 22);
		sx = rnd_signed(scale);
		sy = rnd_signed(scale);
		ox = rnd_signed(scale / 2);
		oy = rnd_signed(scale / 2);
		wild = $urandom_range(9) == 0;
		sp = wild ? int'($urandom) : rnd_signed(1 << $urandom_range(14, 20));
		for (int k = 0; k < n; k++) begin
			if (wild)
				send_point(mk($urandom, $urandom, $urandom, k == 0, k == n - 1));
			else if ($urandom_range(19) == 0)
				send_point(mk(rnd_signed(scale * 4), rnd_signed(scale * 4), $urandom,
					$urandom_range(1), $urandom_range(1)));
			else
				send_point(mk(ox + k * sx + rnd_signed(scale / 16),
					oy + k * sy + rnd_signed(scale / 16), sp, k == 0, k == n - 1));
		end
	endtask

	task automatic random_config();
		set_config($urandom_range(MAX_LT), $urandom_range(MAX_LEN / 8),
			$urandom_range(MAX_LEN), $urandom_range(1));
	endtask

	task automatic test_directed();
		// Before any first point the lookahead is zero and (0,0) is the previous point.
		send_point(mk(32'sh0001_0000, 32'sh0000_8000, 0, 0, 0));
		send_point(mk(5, 5, 0, 0, 0));
		// A fresh path at full speed, both coordinate extremes.
		send_point(mk(0, 0, 32'sh8000_0000, 1, 0));
		send_point(mk(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 1));
		send_point(mk(7, 7, 0, 0, 1));
		// Nothing reaches the circle: the last point is given.
		send_point(mk(100, -100, 32'sh0001_0000, 1, 0));
		send_point(mk(-200, 300, 0, 0, 1));
		// Repeated point nearer than the first, so no segment of zero length is reached.
		send_point(mk(32'sh0004_0000, 0, 32'sh0001_0000, 1, 0));
		send_point(mk(32'sh0001_0000, 32'sh0001_0000, 0, 0, 0));
		send_point(mk(32'sh0001_0000, 32'sh0001_0000, 0, 0, 0));
		// A path that stays just inside the circle at the reset lookahead: the last point is given.
		send_point(mk(32'sh0000_9000, 32'sh0000_9000, -32'sh0001_0000, 1, 0));
		send_point(mk(32'sh0000_9A00, 32'sh0000_8A00, 0, 0, 0));
		send_point(mk(32'sh0000_A000, 32'sh0000_A000, 0, 0, 1));
		// A far first point reaches the circle at once and is given itself.
		send_point(mk(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1, 0));
		send_point(mk(10, 10, 0, 0, 0));
		send_point(mk(-32'sh0002_0000, 32'sh0000_3000, 0, 0, 1));
	endtask

	task automatic test_config_extremes();
		set_config(0, 0, 0, 1);
		test_directed();
		set_config(MAX_LT, MAX_LEN, 0, 1);
		test_directed();
		set_config(MAX_LT, 0, MAX_LEN, 0);
		test_directed();
		set_config((1 << LT_WIDTH) - 1, (1 << LEN_WIDTH) - 1, (1 << LEN_WIDTH) - 1, 1);
		for (int i = 0; i < 4; i++)
			send_path();
	endtask

	task automatic test_random_paths(input int idle_pct, input int stall_pct);
		send_idle = idle_pct;
		recv_stall = stall_pct;
		for (int i = 0; i < 2; i++) begin
			random_config();
			for (int j = 0; j < 15; j++)
				send_path();
		end
	endtask

	task automatic test_backpressure();
		send_idle = 0;
		recv_stall = 0;
		hold_left = 3000;
		for (int i = 0; i < 10; i++)
			send_path();
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			carrot_ch.ready = 1'b0;
			hold_left--;
		end else
			carrot_ch.ready = $urandom_range(99) >= recv_stall;
	end

	always @(posedge clk) begin
		carrot_t want;
		if (arst_n && carrot_ch.valid && carrot_ch.ready) begin
			if (pending_carrots.size() == 0) begin
				$display("%0t: unexpected carrot beat x=%0d y=%0d", $time,
					carrot_ch.carrot_x, carrot_ch.carrot_y);
				errors++;
			end else begin
				want = pending_carrots.pop_front();
				if (carrot_ch.carrot_x !== want.x || carrot_ch.carrot_y !== want.y ||
						carrot_ch.interpolated !== want.interp ||
						carrot_ch.from_path_end !== want.path_end) begin
					$display("%0t: expected x=%0d y=%0d interp=%0b end=%0b, got x=%0d y=%0d interp=%0b end=%0b",
						$time, want.x, want.y, want.interp, want.path_end,
						carrot_ch.carrot_x, carrot_ch.carrot_y,
						carrot_ch.interpolated, carrot_ch.from_path_end);
					errors++;
				end
			end
		end
	end

	initial begin
		path_ch.valid = 1'b0;
		path_ch.point_x = '0;
		path_ch.point_y = '0;
		path_ch.speed_x = '0;
		path_ch.first_point = 1'b0;
		path_ch.last_point = 1'b0;
		carrot_ch.ready = 1'b0;
		la_time = RST_LA_TIME;
		min_la = RST_MIN_LA;
		max_la = RST_MAX_LA;
		use_interp = 1'b1;
		look_dist = '0;
		prev_x = '0;
		prev_y = '0;
		carrot_given = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_config_extremes();
		test_random_paths(0, 0);
		test_random_paths(49, 0);
		test_random_paths(0, 49);
		test_random_paths(15, 15);
		test_backpressure();
		set_config(RST_LA_TIME, RST_MIN_LA, RST_MAX_LA, 1);
		test_random_paths(0, 0);
		wait_idle();
		if (errors == 0 && pending_carrots.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: files.f
hdl/lpf_pkg.sv
hdl/lpf_if.sv
hdl/lpf_alu.sv
hdl/lookahead_point_finder.sv
hdl/lpf_checker.sv
tb/sv/lookahead_point_finder_tb.sv
